[rtl/rcga_pkg.sv]
// Shared types and codes for the reference-counted clock gate arbiter.
// Depends on nothing; imported by refcounted_clock_gate_arbiter.
package rcga_pkg;

  // Request actions
  localparam logic [1:0] ACT_GET       = 2'd0;
  localparam logic [1:0] ACT_PUT       = 2'd1;
  localparam logic [1:0] ACT_UNSUP     = 2'd2;
  localparam logic [1:0] ACT_PEER_GONE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_RELEASED    = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // Configuration register index (byte address 8*i, index in paddr[3])
  localparam logic REG_VIDEO_MASK = 1'b0;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 8;
  localparam int GEN_W   = 32;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 16;
  localparam int EN_W    = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;

  typedef logic [CNT_W-1:0] count_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } seq_state_t;

endpackage

[rtl/refcounted_clock_gate_arbiter.sv]
// Top level of the reference-counted clock gate arbiter: vote counter memory,
// request sequencer with one shared increment/decrement unit, APB register.
// Depends on rcga_pkg.
// Sequence: capture, counter memory read, update through the shared +/-1 adder;
//   one item at a time, and the update waits while the result register is full.
// Reset (rst_n, synchronous, active low): all vote counters read as zero
//   through cleared enable bits, owner generation, domain power and mask clear.
module refcounted_clock_gate_arbiter #(
  parameter int NUM_CLOCKS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: action[1:0], clock_index[9:2], request_generation[41:10],
  //           current_generation[73:42], zero pad [79:74]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rcga_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: status[2:0], vote_count[18:3], clock_enables[82:19],
  //            video_power_on[83], zero pad [87:84]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rcga_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rcga_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rcga_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rcga_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import rcga_pkg::*;

  localparam int CLK_IDX_W = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
  localparam logic [IDX_W-1:0] NUM_CLOCKS_IDX = IDX_W'(NUM_CLOCKS);

  // Unpack the input transfer
  logic [ACT_W-1:0] in_action;
  logic [IDX_W-1:0] in_index;
  logic [GEN_W-1:0] in_req_gen;
  logic [GEN_W-1:0] in_cur_gen;
  assign in_action  = in_tdata[1:0];
  assign in_index   = in_tdata[9:2];
  assign in_req_gen = in_tdata[41:10];
  assign in_cur_gen = in_tdata[73:42];

  // Control state
  seq_state_t              state_r, state_nxt;
  logic [NUM_CLOCKS-1:0]   en_r, en_nxt;
  logic                    dom_r, dom_nxt;
  logic [GEN_W-1:0]        owner_r, owner_nxt;
  logic [EN_W-1:0]         mask_r;
  logic                    out_valid_r, out_valid_nxt;

  // Captured request (payload)
  logic [ACT_W-1:0]        act_r;
  logic [CLK_IDX_W-1:0]    idx_r;
  logic [GEN_W-1:0]        gen_r;
  logic                    valid_req_r;

  // Counter memory
  count_t                  mem [NUM_CLOCKS];
  count_t                  rd_data_r;
  logic                    mem_we;
  count_t                  mem_wdata;

  // Result register (payload)
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  count_t                  res_count_r, res_count_nxt;
  logic [EN_W-1:0]         res_en_r, res_en_nxt;
  logic                    res_dom_r, res_dom_nxt;

  logic                    in_xfer;
  logic                    res_free;
  logic                    cfg_wr;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign res_free  = !out_valid_r || out_tready;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_VIDEO_MASK) ? mask_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr && (cfg_paddr[3] == REG_VIDEO_MASK)) begin
      mask_r <= cfg_pwdata;
    end
  end

  // Capture the request and check it against the link generation
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r       <= in_action;
      idx_r       <= in_index[CLK_IDX_W-1:0];
      gen_r       <= in_req_gen;
      valid_req_r <= (in_req_gen != '0) && (in_req_gen == in_cur_gen) &&
                     (in_index < NUM_CLOCKS_IDX);
    end
  end

  // Counter memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // Update step: shared +/-1 unit, enable bits, domain power
  logic                  clr;
  logic [NUM_CLOCKS-1:0] en_base;
  logic                  dom_base;
  count_t                cnt;
  count_t                sum;
  logic                  is_video;
  logic                  is_getput;
  logic                  at_limit;
  logic [NUM_CLOCKS-1:0] en_new;

  always_comb begin
    clr       = (owner_r != gen_r);
    en_base   = clr ? '0 : en_r;
    dom_base  = clr ? 1'b0 : dom_r;
    cnt       = en_base[idx_r] ? rd_data_r : '0;
    sum       = cnt + ((act_r == ACT_GET) ? count_t'(1) : {CNT_W{1'b1}});
    is_video  = mask_r[idx_r];
    is_getput = (act_r == ACT_GET) || (act_r == ACT_PUT);
    at_limit  = (act_r == ACT_GET) ? (cnt == {CNT_W{1'b1}}) : (cnt == '0);
    en_new    = en_base;
    en_new[idx_r] = (sum != '0);

    state_nxt      = state_r;
    en_nxt         = en_r;
    dom_nxt        = dom_r;
    owner_nxt      = owner_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mem_we         = 1'b0;
    mem_wdata      = sum;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_en_nxt     = res_en_r;
    res_dom_nxt    = res_dom_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register is free
        if (res_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (act_r == ACT_PEER_GONE) begin
            en_nxt         = '0;
            dom_nxt        = 1'b0;
            owner_nxt      = '0;
            res_status_nxt = ST_OK;
            res_count_nxt  = '0;
          end else if (!valid_req_r) begin
            res_status_nxt = ST_INVALID;
            res_count_nxt  = '0;
          end else begin
            owner_nxt      = gen_r;
            en_nxt         = en_base;
            dom_nxt        = dom_base;
            res_count_nxt  = cnt;
            if (!is_getput) begin
              res_status_nxt = ST_UNSUPPORTED;
            end else if (at_limit) begin
              res_status_nxt = (act_r == ACT_GET) ? ST_OVERFLOW : ST_RELEASED;
            end else begin
              res_status_nxt = ST_OK;
              res_count_nxt  = sum;
              en_nxt         = en_new;
              mem_we         = 1'b1;
              if (is_video) begin
                dom_nxt = |(en_new & mask_r[NUM_CLOCKS-1:0]);
              end
            end
          end
          res_en_nxt  = EN_W'(en_nxt);
          res_dom_nxt = dom_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= '0;
      dom_r       <= 1'b0;
      owner_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      dom_r       <= dom_nxt;
      owner_r     <= owner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_en_r     <= res_en_nxt;
    res_dom_r    <= res_dom_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_dom_r, res_en_r, res_count_r, res_status_r};

endmodule

[bench/refcounted_clock_gate_arbiter_tb.sv]
// Self-checking bench for refcounted_clock_gate_arbiter: directed requests, a short counter
// walk, then random request streams under changing video domain masks.
// Depends on rcga_pkg and the arbiter RTL; each reply is checked against a typed reply or an in-bench model.
`timescale 1ns / 100ps

module refcounted_clock_gate_arbiter_tb;
  import rcga_pkg::*;

  localparam int N_CLK       = 64;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int WALK_ITEMS  = 16;
  localparam logic [CFG_ADDR_W-1:0] ADDR_VIDEO_MASK = {REG_VIDEO_MASK, 3'b000};

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] req_gen;
    logic [GEN_W-1:0] cur_gen;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    count_t            count;
    logic [EN_W-1:0]   enables;
    logic              power;
  } reply_t;

  typedef struct packed {
    req_t   req;
    logic   known;
    reply_t reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid;
  logic in_tready;
  // in_tdata: action, clock_index, request_generation, current_generation, zero pad
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata: status, vote_count, clock_enables, video_power_on, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Model state of the arbiter
  count_t           votes [N_CLK];
  logic [GEN_W-1:0] owner_gen;
  logic             powered;
  logic [EN_W-1:0]  video_mask;

  reply_t due_replies [$];
  int     mismatches = 0;
  int     cycle_no = 0;
  int     idle_level = 0;
  int     rx_stall = 0;
  int     hold_asks = 0;
  int     hold_done = 0;
  logic [GEN_W-1:0] link_gen;

  // Directed requests; a reply is typed in only where it is obvious
  dir_row_t dir_rows [20] = '{
    '{'{ACT_PUT, 8'd0, 32'd1, 32'd1}, 1'b1, '{ST_RELEASED, 16'd0, 64'h0, 1'b0}},
    '{'{ACT_GET, 8'd0, 32'd1, 32'd1}, 1'b1, '{ST_OK, 16'd1, 64'h1, 1'b1}},
    '{'{ACT_GET, 8'd64, 32'd1, 32'd1}, 1'b1, '{ST_INVALID, 16'd0, 64'h1, 1'b1}},
    '{'{ACT_GET, 8'd255, 32'd1, 32'd1}, 1'b1, '{ST_INVALID, 16'd0, 64'h1, 1'b1}},
    '{'{ACT_GET, 8'd1, 32'd0, 32'd0}, 1'b1, '{ST_INVALID, 16'd0, 64'h1, 1'b1}},
    '{'{ACT_PUT, 8'd1, 32'd1, 32'd2}, 1'b1, '{ST_INVALID, 16'd0, 64'h1, 1'b1}},
    '{'{ACT_UNSUP, 8'd63, 32'd1, 32'd1}, 1'b1, '{ST_UNSUPPORTED, 16'd0, 64'h1, 1'b1}},
    '{'{ACT_GET, 8'd63, 32'd1, 32'd1}, 1'b1,
      '{ST_OK, 16'd1, 64'h8000_0000_0000_0001, 1'b1}},
    '{'{ACT_PUT, 8'd0, 32'd1, 32'd1}, 1'b0, '0},
    '{'{ACT_PUT, 8'd63, 32'd1, 32'd1}, 1'b0, '0},
    '{'{ACT_GET, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{ACT_GET, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{ACT_GET, 8'd6, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
    '{'{ACT_UNSUP, 8'd6, 32'h1234_5678, 32'h1234_5678}, 1'b1,
      '{ST_UNSUPPORTED, 16'd0, 64'h0, 1'b0}},
    '{'{ACT_GET, 8'd10, 32'h1234_5678, 32'h1234_5678}, 1'b0, '0},
    '{'{ACT_PEER_GONE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{ST_OK, 16'd0, 64'h0, 1'b0}},
    '{'{ACT_GET, 8'd10, 32'h1234_5678, 32'h1234_5678}, 1'b0, '0},
    '{'{ACT_PUT, 8'd10, 32'h1234_5678, 32'h1234_5679}, 1'b1,
      '{ST_INVALID, 16'd0, 64'h400, 1'b1}},
    '{'{ACT_PEER_GONE, 8'd0, 32'd0, 32'd0}, 1'b1, '{ST_OK, 16'd0, 64'h0, 1'b0}},
    '{'{ACT_UNSUP, 8'd64, 32'd1, 32'd1}, 1'b1, '{ST_INVALID, 16'd0, 64'h0, 1'b0}}
  };

  refcounted_clock_gate_arbiter #(.NUM_CLOCKS(N_CLK)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clear every vote, the domain power and the owning generation
  function automatic void drop_all_votes();
    foreach (votes[k]) votes[k] = '0;
    powered = 1'b0;
    owner_gen = '0;
  endfunction

  function automatic logic [EN_W-1:0] enables_of();
    logic [EN_W-1:0] e;
    e = '0;
    for (int k = 0; k < N_CLK; k++) e[k] = (votes[k] != '0);
    return e;
  endfunction

  // Apply one request to the model state and return the reply it produces
  function automatic reply_t apply_request(input req_t r);
    reply_t y;
    int     c;
    logic   video;
    y = '0;
    y.status = ST_OK;
    c = int'(r.idx);
    if (r.action == ACT_PEER_GONE) begin
      drop_all_votes();
    end else if (r.req_gen == '0 || r.req_gen != r.cur_gen || c >= N_CLK) begin
      y.status = ST_INVALID;
    end else begin
      video = video_mask[c];
      if (owner_gen != r.req_gen) begin
        drop_all_votes();
        owner_gen = r.req_gen;
      end
      case (r.action)
        ACT_GET: begin
          if (votes[c] == 16'hFFFF) y.status = ST_OVERFLOW;
          else votes[c] = votes[c] + 16'd1;
        end
        ACT_PUT: begin
          if (votes[c] == '0) y.status = ST_RELEASED;
          else votes[c] = votes[c] - 16'd1;
        end
        default: y.status = ST_UNSUPPORTED;
      endcase
      if (y.status == ST_OK && video) powered = |(enables_of() & video_mask);
      y.count = votes[c];
    end
    y.enables = enables_of();
    y.power = powered;
    return y;
  endfunction

  // Mostly well-formed traffic on the live generation, with some noise mixed in
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    r.action = ACT_GET;
    r.idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(N_CLK - 1))
                                     : IDX_W'($urandom_range(7));
    r.req_gen = link_gen;
    r.cur_gen = link_gen;
    if (roll < 3) begin
      r.action = ACT_PEER_GONE;
      r.idx = IDX_W'($urandom);
      r.req_gen = $urandom;
      r.cur_gen = $urandom;
    end else if (roll < 9) begin
      r.action = ACT_W'($urandom_range(2));
      case ($urandom_range(2))
        0: begin
          r.req_gen = '0;
          r.cur_gen = $urandom_range(1) ? '0 : link_gen;
        end
        1: r.cur_gen = r.req_gen ^ (32'h1 << $urandom_range(31));
        default: r.idx = IDX_W'($urandom_range(N_CLK, 255));
      endcase
    end else if (roll < 12) begin
      do link_gen = $urandom; while (link_gen == '0);
      r.req_gen = link_gen;
      r.cur_gen = link_gen;
    end else if (roll < 15) begin
      r.action = ACT_UNSUP;
    end else if (roll >= 60) begin
      r.action = ACT_PUT;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Offer one request, hold it until the transfer, then queue its reply
  task automatic send_request(input req_t r, input logic known, input reply_t typed);
    reply_t y;
    if (idle_level != 0 && $urandom_range(9) < idle_level) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, r.cur_gen, r.req_gen, r.idx, r.action};
    do @(posedge clk); while (!in_tready);
    y = apply_request(r);
    due_replies.push_back(known ? typed : y);
  endtask

  // Drop the input and wait until every reply is back and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the video domain mask, then read it back
  task automatic write_mask(input logic [CFG_DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_VIDEO_MASK;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val)
      note_mismatch($sformatf("mask readback expected %h, got %h", val, cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    video_mask = val;
  endtask

  // Receiver: random stalls, plus one long hold when the stimulus asks for it
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall <= 0;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      rx_stall <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      out_tready <= 1'b0;
    end else if (idle_level != 0 && $urandom_range(9) < idle_level) begin
      rx_stall <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each reply transfer with the oldest queued reply
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[2:0];
      got.count   = out_tdata[18:3];
      got.enables = out_tdata[82:19];
      got.power   = out_tdata[83];
      if (due_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected reply status %0d count %0d enables %h power %b",
                                got.status, got.count, got.enables, got.power));
      end else begin
        want = due_replies.pop_front();
        if (got !== want)
          note_mismatch($sformatf({"expected status %0d count %0d enables %h power %b, ",
                                   "got status %0d count %0d enables %h power %b"},
                                  want.status, want.count, want.enables, want.power,
                                  got.status, got.count, got.enables, got.power));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_masks [PHASES];
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    drop_all_votes();
    video_mask = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, all clocks in the video domain
    write_mask('1);
    idle_level = 1;
    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].known, dir_rows[k].reply);
    settle();

    // Walk one counter up, step back down, then drop all
    write_mask('0);
    idle_level = 0;
    do link_gen = $urandom; while (link_gen == '0);
    repeat (WALK_ITEMS) send_request('{ACT_GET, 8'd17, link_gen, link_gen}, 1'b0, '0);
    send_request('{ACT_PUT, 8'd17, link_gen, link_gen}, 1'b0, '0);
    send_request('{ACT_PEER_GONE, 8'd17, link_gen, link_gen}, 1'b0, '0);
    settle();

    // Random phases, each under its own mask; phases 0, 3, 6 and the last run without idling
    phase_masks = '{64'h0, '1, {$urandom, $urandom}, 64'h1 << $urandom_range(63),
                    64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0001,
                    {$urandom, $urandom}, 64'h5555_5555_5555_5555};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mask(phase_masks[ph]);
      idle_level = (ph == PHASES - 1) ? 0 : (ph % 3) * 2;
      if (ph == 1) hold_asks++;
      repeat (PHASE_ITEMS) send_request(pick_request(), 1'b0, '0);
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
